### rtl/dcl_pkg.sv
// Package for the deduplicating compacting list: sizes, operation and
// status codes, and the memory write request type. No dependencies.
package dcl_pkg;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned HW    = 16;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned CMPW  = (CW > 8) ? CW : 8;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_RM_POS = 2'd1;
  localparam logic [1:0] MODE_RM_HDL = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_DUP  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;
  localparam logic [1:0] STAT_BAD  = 2'd3;

  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    logic [HW-1:0] data;
  } mem_wr_t;

endpackage

### rtl/dedup_compacting_list_top.sv
// Deduplicating compacting list: top level with the scan sequencer and output register.
// An item streams the entries it scans in SCAN and forms its result in FINISH; one that
// scans nothing (a rejected remove at position, a read of an empty list) reads no entry.
// A read scans one entry, an insert or remove by handle the whole list, a remove at position
// from that slot to the end. One item is in work at a time; the next transaction can be
// accepted as soon as the result appears. Reset clears the count and control state only.
module dedup_compacting_list_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] handle_i,
  input  logic signed [7:0] position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] read_handle_o,
  output logic [5:0]  entry_count_o
);
  import dcl_pkg::*;

  // Sequencer states. SCAN streams entries through the memory read port; FINISH
  // forms the result and waits for the output register to be free.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [1:0]    mode_q;
  logic [HW-1:0] handle_q;
  logic          bad_q, bad_d;
  logic          hit_q, hit_d;
  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] lim_q, lim_d;
  logic          p_vld_q, p_vld_d;
  logic [AW-1:0] p_idx_q, p_idx_d;
  logic [HW-1:0] rdh_q, rdh_d;

  logic          out_vld_q, out_vld_d;
  logic [1:0]    out_stat_q, out_stat_d;
  logic [HW-1:0] out_hdl_q, out_hdl_d;
  logic [CW-1:0] out_cnt_q, out_cnt_d;

  logic          in_acc;
  logic          out_free;
  logic          issue;
  logic          rd_en;
  logic [HW-1:0] rd_data;
  mem_wr_t       wr;

  logic          pos_neg;
  logic [CMPW-1:0] pos_ext, cnt_ext;
  logic          pos_ge;
  logic [CW-1:0] start_c, lim_c, idx_c;
  logic          bad_c;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_free   = !out_vld_q || out_ready_i;
  assign issue      = (state_q == S_SCAN) && (k_q < lim_q);
  assign rd_en      = issue;

  // Position checks at acceptance. A negative position is invalid for a remove
  // and clamps to the first entry for a read.
  assign pos_neg = position_i[7];
  assign pos_ext = CMPW'($unsigned(position_i));
  assign cnt_ext = CMPW'(cnt_q);
  assign pos_ge  = !pos_neg && (pos_ext >= cnt_ext);

  always_comb begin
    start_c = '0;
    lim_c   = cnt_q;
    bad_c   = 1'b0;
    idx_c   = '0;
    case (mode_i)
      MODE_INSERT: begin
        start_c = '0;
        lim_c   = cnt_q;
      end
      MODE_RM_POS: begin
        bad_c = pos_neg || pos_ge;
        if (bad_c) begin
          start_c = '0;
          lim_c   = '0;
        end else begin
          start_c = pos_ext[CW-1:0];
          lim_c   = cnt_q;
        end
      end
      MODE_RM_HDL: begin
        start_c = '0;
        lim_c   = cnt_q;
      end
      MODE_READ: begin
        if (cnt_q == '0) begin
          start_c = '0;
          lim_c   = '0;
        end else begin
          if (pos_neg) begin
            idx_c = '0;
          end else if (pos_ge) begin
            idx_c = cnt_q - CW'(1);
          end else begin
            idx_c = pos_ext[CW-1:0];
          end
          start_c = idx_c;
          lim_c   = idx_c + CW'(1);
        end
      end
      default: begin
        start_c = '0;
        lim_c   = '0;
      end
    endcase
  end

  // Main sequencer. During a scan the read of entry k is issued while the data
  // of entry k-1 is checked. Once a remove has found its slot, every later entry
  // is written one slot lower; those writes always trail the reads, so no entry
  // is read after it has been rewritten within the same scan.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    bad_d      = bad_q;
    hit_d      = hit_q;
    k_d        = k_q;
    lim_d      = lim_q;
    p_vld_d    = 1'b0;
    p_idx_d    = p_idx_q;
    rdh_d      = rdh_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    out_stat_d = out_stat_q;
    out_hdl_d  = out_hdl_q;
    out_cnt_d  = out_cnt_q;
    wr         = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          bad_d   = bad_c;
          hit_d   = 1'b0;
          k_d     = start_c;
          lim_d   = lim_c;
          rdh_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue) begin
          k_d     = k_q + CW'(1);
          p_vld_d = 1'b1;
          p_idx_d = k_q[AW-1:0];
        end
        if (p_vld_q) begin
          case (mode_q)
            MODE_INSERT: begin
              if (rd_data == handle_q) begin
                hit_d = 1'b1;
              end
            end
            MODE_RM_POS, MODE_RM_HDL: begin
              if (hit_q) begin
                wr.en   = 1'b1;
                wr.addr = p_idx_q - AW'(1);
                wr.data = rd_data;
              end else if (mode_q == MODE_RM_POS || rd_data == handle_q) begin
                // A remove at position starts its scan at the slot to drop.
                hit_d = 1'b1;
              end
            end
            MODE_READ: begin
              rdh_d = rd_data;
            end
            default: begin
              hit_d = hit_q;
            end
          endcase
        end
        if (!issue && !p_vld_q) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_hdl_d  = '0;
          out_stat_d = STAT_DONE;
          case (mode_q)
            MODE_INSERT: begin
              if (hit_q) begin
                out_stat_d = STAT_DUP;
              end else if (cnt_q == CW'(DEPTH)) begin
                out_stat_d = STAT_FULL;
              end else begin
                wr.en   = 1'b1;
                wr.addr = cnt_q[AW-1:0];
                wr.data = handle_q;
                cnt_d   = cnt_q + CW'(1);
              end
            end
            MODE_RM_POS: begin
              if (bad_q || !hit_q) begin
                out_stat_d = STAT_BAD;
              end else begin
                cnt_d = cnt_q - CW'(1);
              end
            end
            MODE_RM_HDL: begin
              if (hit_q) begin
                cnt_d = cnt_q - CW'(1);
              end else begin
                out_stat_d = STAT_BAD;
              end
            end
            MODE_READ: begin
              if (cnt_q == '0) begin
                out_stat_d = STAT_BAD;
              end else begin
                out_hdl_d = rdh_q;
              end
            end
            default: begin
              out_stat_d = STAT_BAD;
            end
          endcase
          out_cnt_d = cnt_d;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      p_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      bad_q     <= 1'b0;
      k_q       <= '0;
      lim_q     <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      p_vld_q   <= p_vld_d;
      out_vld_q <= out_vld_d;
      hit_q     <= hit_d;
      bad_q     <= bad_d;
      k_q       <= k_d;
      lim_q     <= lim_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q   <= mode_i;
      handle_q <= handle_i[HW-1:0];
    end
    p_idx_q    <= p_idx_d;
    rdh_q      <= rdh_d;
    out_stat_q <= out_stat_d;
    out_hdl_q  <= out_hdl_d;
    out_cnt_q  <= out_cnt_d;
  end

  dcl_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (k_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  assign out_valid_o   = out_vld_q;
  assign status_o      = out_stat_q;
  assign read_handle_o = 16'(out_hdl_q);
  assign entry_count_o = 6'(out_cnt_q);

endmodule

### rtl/dcl_mem.sv
// Entry store of the list: one write port and one registered read port.
// Depends on dcl_pkg for sizes and the write request type.
module dcl_mem (
  input  logic                      clk_i,
  input  dcl_pkg::mem_wr_t          wr_i,
  input  logic                      rd_en_i,
  input  logic [dcl_pkg::AW-1:0]    rd_addr_i,
  output logic [dcl_pkg::HW-1:0]    rd_data_o
);
  import dcl_pkg::*;

  logic [HW-1:0] mem_q [DEPTH];
  logic [HW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### tb/sv/dedup_compacting_list_top_test.sv
// Self-checking testbench for dedup_compacting_list_top: a directed table, then random
// phases of list operations, each result checked against a typed-in reply or a behavioral list predictor.
// Depends on dcl_pkg and the dedup_compacting_list_top RTL.
`timescale 1ns / 1ps

module dedup_compacting_list_top_test;
  import dcl_pkg::*;

  // Run sizing. A single item scans at most DEPTH entries, so the tail after the last
  // result only has to cover one scan.
  localparam int ITEM_TOTAL       = 1850;
  localparam int TAIL_CYCLES      = 2 * DEPTH + 10;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int PRINT_CAP        = 100;
  localparam longint LIMIT_NS     = 64'd10_000_000;

  // What one result transaction carries.
  typedef struct packed {
    logic [1:0]    status;
    logic [HW-1:0] read_handle;
    logic [5:0]    entry_count;
  } list_reply_t;

  // One row of the directed table. When pinned is set, the reply is typed in by hand
  // and checked as written; otherwise the predictor supplies it.
  typedef struct packed {
    logic [1:0]        mode;
    logic [HW-1:0]     handle;
    logic signed [7:0] pos;
    logic              pinned;
    list_reply_t       reply;
  } dir_row_t;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_NOISE} phase_kind_e;

  localparam int DIR_ROWS_N = 24;
  localparam list_reply_t NO_REPLY = '0;

  // The directed walk: empty-list errors, inserts at the handle extremes, a duplicate,
  // reads clamped from both ends, removals out of range on both sides, a missing handle,
  // and removals at the front by position and by handle.
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{MODE_READ,   16'h0000, 8'h00, 1'b1, '{STAT_BAD,  16'h0000, 6'd0}},
    '{MODE_RM_POS, 16'h0000, 8'h00, 1'b1, '{STAT_BAD,  16'h0000, 6'd0}},
    '{MODE_RM_HDL, 16'h0000, 8'h00, 1'b1, '{STAT_BAD,  16'h0000, 6'd0}},
    '{MODE_INSERT, 16'hFFFF, 8'h00, 1'b1, '{STAT_DONE, 16'h0000, 6'd1}},
    '{MODE_INSERT, 16'h0000, 8'h7F, 1'b1, '{STAT_DONE, 16'h0000, 6'd2}},
    '{MODE_INSERT, 16'hFFFF, 8'h80, 1'b1, '{STAT_DUP,  16'h0000, 6'd2}},
    '{MODE_INSERT, 16'h8001, 8'h00, 1'b1, '{STAT_DONE, 16'h0000, 6'd3}},
    '{MODE_READ,   16'hFFFF, 8'h80, 1'b1, '{STAT_DONE, 16'hFFFF, 6'd3}},
    '{MODE_READ,   16'h0000, 8'h7F, 1'b1, '{STAT_DONE, 16'h8001, 6'd3}},
    '{MODE_READ,   16'h0000, 8'h01, 1'b1, '{STAT_DONE, 16'h0000, 6'd3}},
    '{MODE_RM_POS, 16'h0000, 8'hFF, 1'b1, '{STAT_BAD,  16'h0000, 6'd3}},
    '{MODE_RM_POS, 16'h0000, 8'h03, 1'b1, '{STAT_BAD,  16'h0000, 6'd3}},
    '{MODE_RM_POS, 16'hFFFF, 8'h80, 1'b1, '{STAT_BAD,  16'h0000, 6'd3}},
    '{MODE_RM_HDL, 16'h1234, 8'h00, 1'b1, '{STAT_BAD,  16'h0000, 6'd3}},
    '{MODE_RM_POS, 16'h0000, 8'h00, 1'b1, '{STAT_DONE, 16'h0000, 6'd2}},
    '{MODE_READ,   16'h0000, 8'h00, 1'b0, NO_REPLY},
    '{MODE_RM_HDL, 16'h8001, 8'h00, 1'b1, '{STAT_DONE, 16'h0000, 6'd1}},
    '{MODE_INSERT, 16'h5AA5, 8'h00, 1'b0, NO_REPLY},
    '{MODE_INSERT, 16'hA55A, 8'h00, 1'b0, NO_REPLY},
    '{MODE_RM_HDL, 16'h0000, 8'h00, 1'b0, NO_REPLY},
    '{MODE_READ,   16'h0000, 8'h01, 1'b0, NO_REPLY},
    '{MODE_RM_POS, 16'h0000, 8'h7F, 1'b1, '{STAT_BAD,  16'h0000, 6'd2}},
    '{MODE_INSERT, 16'h0000, 8'h00, 1'b0, NO_REPLY},
    '{MODE_READ,   16'h0000, 8'h02, 1'b0, NO_REPLY}
  };

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_mode;
  logic [HW-1:0]     in_handle;
  logic signed [7:0] in_pos;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        out_status;
  logic [15:0]       out_read_handle;
  logic [5:0]        out_entry_count;

  // Predictor state: a private copy of the packed list and its fill level.
  logic [HW-1:0] list_slots [DEPTH];
  int            list_fill;

  // Replies owed by the block, oldest first.
  list_reply_t   owed_replies [$];

  int  mismatch_count;
  int  items_sent;
  bit  calm_phase;
  bit  long_hold_req;

  dedup_compacting_list_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .mode_i        (in_mode),
    .handle_i      (in_handle),
    .position_i    (in_pos),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (out_status),
    .read_handle_o (out_read_handle),
    .entry_count_o (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs on either handshake.
  initial begin
    #(LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // Idle length for either side: mostly none or a few cycles, now and then a long one.
  // During a calm phase both sides run back to back.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm_phase) return 0;
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Removes one slot and closes the gap by moving every later entry down.
  function automatic void close_gap(input int slot);
    for (int k = slot; k < list_fill - 1; k++) begin
      list_slots[k] = list_slots[k + 1];
    end
    list_fill--;
  endfunction

  // Applies one list operation to the predictor and returns the reply it owes.
  // The duplicate check comes before the full check, reads clamp into the list,
  // and only the first matching slot is removed by handle.
  function automatic list_reply_t apply_list_op(input logic [1:0] op,
                                                input logic [HW-1:0] hdl,
                                                input logic signed [7:0] pos);
    list_reply_t rep;
    int          pos_v;
    int          hit;
    int          idx;
    rep   = '0;
    pos_v = pos;
    hit   = -1;
    rep.status = STAT_DONE;
    for (int k = 0; k < list_fill; k++) begin
      if (hit < 0 && list_slots[k] == hdl) hit = k;
    end
    case (op)
      MODE_INSERT: begin
        if (hit >= 0) begin
          rep.status = STAT_DUP;
        end else if (list_fill >= DEPTH) begin
          rep.status = STAT_FULL;
        end else begin
          list_slots[list_fill] = hdl;
          list_fill++;
        end
      end
      MODE_RM_POS: begin
        if (pos_v < 0 || pos_v >= list_fill) rep.status = STAT_BAD;
        else close_gap(pos_v);
      end
      MODE_RM_HDL: begin
        if (hit < 0) rep.status = STAT_BAD;
        else close_gap(hit);
      end
      default: begin
        if (list_fill == 0) begin
          rep.status = STAT_BAD;
        end else begin
          idx = (pos_v < 0) ? 0 : (pos_v >= list_fill) ? list_fill - 1 : pos_v;
          rep.read_handle = list_slots[idx];
        end
      end
    endcase
    rep.entry_count = list_fill[5:0];
    return rep;
  endfunction

  // Offers one transaction and holds it until accepted. The reply is worked out at
  // acceptance. After it the valid either stays up for the next item or drops for a gap,
  // so valid never gets two assignments in one time step.
  task automatic offer_item(input logic [1:0] op, input logic [HW-1:0] hdl,
                            input logic signed [7:0] pos, input bit pinned,
                            input list_reply_t pinned_reply);
    list_reply_t predicted;
    int          gap;
    in_valid  <= 1'b1;
    in_mode   <= op;
    in_handle <= hdl;
    in_pos    <= pos;
    do @(posedge clk); while (!in_ready);
    predicted = apply_list_op(op, hdl, pos);
    owed_replies.push_back(pinned ? pinned_reply : predicted);
    items_sent++;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every owed reply has come back.
  task automatic wait_all_replied();
    in_valid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
  endtask

  // Handle for an item: a stored one with the given odds, else mostly from a small per-phase pool,
  // so that duplicates and later removals by handle hit often, sometimes anything.
  function automatic logic [HW-1:0] pick_handle(input logic [HW-1:0] pool_base,
                                                input int favor_stored);
    int roll;
    roll = $urandom_range(0, 99);
    if (list_fill > 0 && roll < favor_stored) begin
      return list_slots[$urandom_range(0, list_fill - 1)];
    end
    if (roll < 85) return pool_base ^ HW'($urandom_range(0, 47));
    return HW'($urandom);
  endfunction

  // Position: mostly in or just past the list, some negative, some anywhere.
  function automatic logic signed [7:0] pick_pos();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 8'($urandom_range(0, list_fill + 1));
    if (roll < 85) return 8'($urandom_range(128, 255));
    return 8'($urandom);
  endfunction

  // Result side: ready is dropped for random stretches, and once for a long hold-off
  // that backs the block up until it stops accepting input.
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        stall = idle_len();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Every accepted result transaction is matched against the oldest owed reply. Values
  // seen right after the edge are still the ones the flops sampled at that edge.
  initial begin : reply_check
    list_reply_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (owed_replies.size() == 0) begin
          flag_mismatch("result transaction with no reply owed");
        end else begin
          want = owed_replies.pop_front();
          if (out_status !== want.status) begin
            flag_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
          end
          if (out_read_handle !== want.read_handle) begin
            flag_mismatch($sformatf("read_handle got %h want %h",
                                    out_read_handle, want.read_handle));
          end
          if (out_entry_count !== want.entry_count) begin
            flag_mismatch($sformatf("entry_count got %0d want %0d",
                                    out_entry_count, want.entry_count));
          end
        end
      end
    end
  end

  initial begin : stimulus
    phase_kind_e   kind;
    logic [HW-1:0] pool_base;
    logic [1:0]    op;
    logic [HW-1:0] hdl;
    logic signed [7:0] pos;
    int            phase_idx;
    int            phase_len;
    int            roll;
    in_valid       = 1'b0;
    in_mode        = MODE_INSERT;
    in_handle      = '0;
    in_pos         = '0;
    rst_n          = 1'b0;
    list_fill      = 0;
    mismatch_count = 0;
    items_sent     = 0;
    calm_phase     = 1'b0;
    long_hold_req  = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[i]) begin
      offer_item(DIR_ROWS[i].mode, DIR_ROWS[i].handle, DIR_ROWS[i].pos,
                 DIR_ROWS[i].pinned, DIR_ROWS[i].reply);
    end

    // Random phases. The first one is a long fill so the list reaches capacity and
    // sees inserts while full, duplicates among them. The second starts quiet, after
    // the sender has waited out every reply. The third runs under the long receiver
    // hold-off while the sender keeps offering.
    phase_idx = 0;
    while (items_sent < ITEM_TOTAL) begin
      roll = $urandom_range(0, 99);
      kind = (roll < 35) ? PH_FILL : (roll < 65) ? PH_DRAIN :
             (roll < 90) ? PH_MIXED : PH_NOISE;
      phase_len = $urandom_range(40, 90);
      if (phase_idx == 0) begin
        kind      = PH_FILL;
        phase_len = 100;
      end
      if (phase_idx == 1 || $urandom_range(0, 2) == 0) wait_all_replied();
      if (phase_idx == 2) long_hold_req = 1'b1;
      calm_phase = ($urandom_range(0, 3) == 0);
      pool_base  = HW'($urandom);

      for (int n = 0; n < phase_len && items_sent < ITEM_TOTAL; n++) begin
        roll = $urandom_range(0, 99);
        case (kind)
          PH_FILL:  op = (roll < 75) ? MODE_INSERT : (roll < 83) ? MODE_RM_HDL :
                         (roll < 88) ? MODE_RM_POS : MODE_READ;
          PH_DRAIN: op = (roll < 20) ? MODE_INSERT : (roll < 55) ? MODE_RM_HDL :
                         (roll < 85) ? MODE_RM_POS : MODE_READ;
          default:  op = 2'($urandom_range(0, 3));
        endcase
        if (kind == PH_NOISE) begin
          hdl = HW'($urandom);
          pos = 8'($urandom);
        end else begin
          hdl = pick_handle(pool_base, (op == MODE_RM_HDL) ? 60 : 15);
          pos = pick_pos();
        end
        offer_item(op, hdl, pos, 1'b0, NO_REPLY);
      end
      phase_idx++;
    end

    wait_all_replied();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && owed_replies.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
